>>> hw/rtl/gpio_controller_edge_level_irq_assert.svh
// Assertion macros used by the GPIO controller checker
`ifndef GPIO_CONTROLLER_EDGE_LEVEL_IRQ_ASSERT_SVH
`define GPIO_CONTROLLER_EDGE_LEVEL_IRQ_ASSERT_SVH

// Same-cycle implication, quiet while reset is applied
`define GPIO_ELI_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("gpio controller check failed");

// Next-cycle implication, quiet while reset is applied
`define GPIO_ELI_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("gpio controller check failed");

`endif

>>> hw/rtl/gpio_eli_pkg.sv
// Types, codes and update functions of the GPIO controller
`timescale 1ns / 1ps

package gpio_eli_pkg;

	localparam int NUM_PINS_DEF = 32;
	localparam int DATA_W       = 32;
	localparam int PIN_W        = 5;

	typedef enum logic [1:0] {
		KIND_READ  = 2'd0,
		KIND_WRITE = 2'd1,
		KIND_PIN   = 2'd2
	} kind_e_t;

	typedef enum logic [2:0] {
		REG_DIR  = 3'd0,
		REG_OUT  = 3'd1,
		REG_IN   = 3'd2,
		REG_IE   = 3'd3,
		REG_IS   = 3'd4,
		REG_TRIG = 3'd5,
		REG_POL  = 3'd6,
		REG_NONE = 3'd7
	} reg_e_t;

	typedef struct packed {
		logic [1:0]        kind;
		logic [2:0]        reg_index;
		logic [DATA_W-1:0] write_value;
		logic [PIN_W-1:0]  pin_index;
	} in_item_t;

	typedef struct packed {
		logic [DATA_W-1:0] read_data;
		logic              irq;
		logic [DATA_W-1:0] drive_lines;
	} out_item_t;

	// Architectural state of the controller
	typedef struct packed {
		logic [DATA_W-1:0] dir;
		logic [DATA_W-1:0] latch;
		logic [DATA_W-1:0] ie;
		logic [DATA_W-1:0] st;
		logic [DATA_W-1:0] trig;
		logic [DATA_W-1:0] pol;
		logic [DATA_W-1:0] lv;
	} regs_t;

	// Set status on enabled edge-mode pins that changed to their active level
	function automatic regs_t latch_edges(regs_t r, logic [DATA_W-1:0] changed,
			logic [DATA_W-1:0] m);
		regs_t o;
		logic [DATA_W-1:0] hit;
		o = r;
		hit = changed & r.ie & ~r.trig & ~(r.lv ^ r.pol);
		o.st = r.st | (hit & m);
		return o;
	endfunction

	// Drive output pins from the latch, catch edges, re-evaluate level status
	function automatic regs_t refresh(regs_t r, logic [DATA_W-1:0] m);
		regs_t o;
		logic [DATA_W-1:0] outs;
		logic [DATA_W-1:0] val;
		logic [DATA_W-1:0] lvl;
		o = r;
		outs = r.dir & m;
		o.lv = (r.lv & ~outs) | (r.latch & outs);
		o = latch_edges(o, (r.lv ^ o.lv) & m, m);
		val = (o.dir & o.latch) | (~o.dir & o.lv);
		lvl = o.ie & o.trig & m;
		o.st = (o.st & ~lvl) | (lvl & ~(val ^ o.pol));
		return o;
	endfunction

endpackage

>>> hw/rtl/gpio_controller_edge_level_irq.sv
// Top level of the GPIO controller with edge and level interrupts
`timescale 1ns / 1ps
// Usage:
//   Input channel (item_valid, item_stall, item) carries bus reads, bus
//   writes and external pin events. Output channel (result_valid,
//   result_stall, result) returns one result per item, in order: read data,
//   the combined irq line and the driven output pin values, all taken after
//   the item's register update.
//   Path: an accepted item is held in the item register, and its result
//   is registered in the result register when the output is free.
//   Throughput: one item per cycle while the result is not stalled; the
//   item register and the result register are separate, and each register
//   update is a single pass of bitwise logic over the 32-bit registers.
//   Reset: the controller registers clear to zero and both stages empty;
//   the result payload is undefined until the first result is valid.
//   Stall: while result_stall holds a waiting result, one more item is
//   taken into the item register; then item_stall rises until the result
//   moves. Register updates happen only when an item moves into the result
//   register, so stalls never change the state.
module gpio_controller_edge_level_irq #(
	parameter int NUM_PINS = gpio_eli_pkg::NUM_PINS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    item_valid,
	output logic                    item_stall,
	input  gpio_eli_pkg::in_item_t  item,
	output logic                    result_valid,
	input  logic                    result_stall,
	output gpio_eli_pkg::out_item_t result
);
	import gpio_eli_pkg::*;

	logic      valid_s1;
	in_item_t  item_s1;
	logic      advance;
	out_item_t res_next;
	out_item_t res_q;

	// Move the held item on when the result register is free or draining
	assign advance    = valid_s1 && (!result_valid || !result_stall);
	assign item_stall = valid_s1 && !advance;

	// Hold the accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!item_stall && item_valid) begin
			item_s1 <= item;
		end
	end

	gpio_eli_core #(
		.NUM_PINS(NUM_PINS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.exec   (advance),
		.item   (item_s1),
		.result (res_next)
	);

	// Register the result and hold it while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (!result_valid || !result_stall) begin
			result_valid <= advance;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_next;
		end
	end

	assign result = res_q;

endmodule

>>> hw/rtl/gpio_eli_core.sv
// Register file and single-pass item execution of the GPIO controller
`timescale 1ns / 1ps

module gpio_eli_core #(
	parameter int NUM_PINS = gpio_eli_pkg::NUM_PINS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   exec,
	input  gpio_eli_pkg::in_item_t item,
	output gpio_eli_pkg::out_item_t result
);
	import gpio_eli_pkg::*;

	localparam logic [63:0] OnesWide = (64'd1 << NUM_PINS) - 64'd1;
	localparam logic [DATA_W-1:0] PinMask = OnesWide[DATA_W-1:0];

	regs_t cur_q;
	regs_t nxt;
	logic [DATA_W-1:0] rd;
	logic [DATA_W-1:0] bit_sel;
	logic              pin_ok;

	assign bit_sel = {{(DATA_W-1){1'b0}}, 1'b1} << item.pin_index;
	assign pin_ok  = {1'b0, item.pin_index} < (PIN_W+1)'(NUM_PINS);

	// Compute the state after the item and the read data
	always_comb begin
		nxt = cur_q;
		rd  = '0;
		unique case (kind_e_t'(item.kind))
			KIND_READ: begin
				unique case (reg_e_t'(item.reg_index))
					REG_DIR:  rd = cur_q.dir;
					REG_OUT:  rd = cur_q.latch;
					REG_IN:   rd = ((cur_q.dir & cur_q.latch) | (~cur_q.dir & cur_q.lv))
							& PinMask;
					REG_IE:   rd = cur_q.ie;
					REG_IS:   rd = cur_q.st;
					REG_TRIG: rd = cur_q.trig;
					REG_POL:  rd = cur_q.pol;
					default:  rd = '0;
				endcase
			end
			KIND_WRITE: begin
				unique case (reg_e_t'(item.reg_index))
					REG_DIR: begin
						nxt.dir = item.write_value;
						nxt = refresh(nxt, PinMask);
					end
					REG_OUT: begin
						nxt.latch = item.write_value;
						nxt = refresh(nxt, PinMask);
					end
					REG_IE:   nxt.ie = item.write_value;
					REG_IS:   nxt.st = cur_q.st & ~item.write_value;
					REG_TRIG: begin
						nxt.trig = item.write_value;
						nxt = refresh(nxt, PinMask);
					end
					REG_POL: begin
						nxt.pol = item.write_value;
						nxt = refresh(nxt, PinMask);
					end
					default: nxt = cur_q;
				endcase
			end
			KIND_PIN: begin
				if (pin_ok) begin
					nxt.lv = item.write_value[0] ? (cur_q.lv | bit_sel) : (cur_q.lv & ~bit_sel);
					nxt = latch_edges(nxt, (cur_q.lv ^ nxt.lv) & PinMask, PinMask);
					nxt = refresh(nxt, PinMask);
				end
			end
			default: nxt = cur_q;
		endcase
	end

	// Commit the state when the item executes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= '0;
		end else if (exec) begin
			cur_q <= nxt;
		end
	end

	// Form the result from the updated state
	assign result.read_data   = rd;
	assign result.irq         = |(nxt.st & nxt.ie);
	assign result.drive_lines = nxt.latch & nxt.dir & PinMask;

endmodule

>>> hw/rtl/gpio_eli_chk.sv
// Port-level checker of the GPIO controller and its bind
`timescale 1ns / 1ps
`include "gpio_controller_edge_level_irq_assert.svh"

module gpio_eli_chk #(
	parameter int NUM_PINS = gpio_eli_pkg::NUM_PINS_DEF
) (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    item_valid,
	input logic                    item_stall,
	input logic                    result_valid,
	input logic                    result_stall,
	input gpio_eli_pkg::out_item_t result
);
	import gpio_eli_pkg::*;

	localparam logic [63:0] OnesWide = (64'd1 << NUM_PINS) - 64'd1;
	localparam logic [DATA_W-1:0] PinMask = OnesWide[DATA_W-1:0];

	// Input side stalls only behind a blocked result
	`GPIO_ELI_ASSERT_IMP(a_stall_cause, item_stall, result_valid && result_stall)
	// An accepted item reaches the output in the cycle after the path is open
	`GPIO_ELI_ASSERT_NXT(a_latency, (item_valid && !item_stall) ##1 !result_stall, result_valid)
	// Driven lines never reach beyond the implemented pins
	`GPIO_ELI_ASSERT_IMP(a_drive_mask, result_valid, (result.drive_lines & ~PinMask) == '0)
	// A blocked result stays put
	`GPIO_ELI_ASSERT_NXT(a_hold, result_valid && result_stall, result_valid && $stable(result))

endmodule

bind gpio_controller_edge_level_irq gpio_eli_chk #(
	.NUM_PINS(NUM_PINS)
) u_gpio_eli_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_stall   (item_stall),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);

>>> tb/gpio_eli_shadow_pkg.sv
// Shadow register model and result checker for the GPIO controller testbench
`timescale 1ns / 1ps

package gpio_eli_shadow_pkg;

	import gpio_eli_pkg::*;

	// Item kind that the controller treats as a no-op
	localparam logic [1:0] KIND_SPARE = 2'd3;

	class gpio_shadow_regs;
		bit [DATA_W-1:0] dir_r;
		bit [DATA_W-1:0] latch_r;
		bit [DATA_W-1:0] ie_r;
		bit [DATA_W-1:0] st_r;
		bit [DATA_W-1:0] trig_r;
		bit [DATA_W-1:0] pol_r;
		bit [DATA_W-1:0] lv_r;
		bit [DATA_W-1:0] pins;
		int              pin_count;
		out_item_t       pending_results[$];
		int              mismatches;

		function new(int num_pins);
			bit [63:0] span;
			span = (64'd1 << num_pins) - 64'd1;
			pins = span[DATA_W-1:0];
			pin_count = num_pins;
			dir_r = '0;
			latch_r = '0;
			ie_r = '0;
			st_r = '0;
			trig_r = '0;
			pol_r = '0;
			lv_r = '0;
			mismatches = 0;
		endfunction

		// Set status on enabled edge-mode pins that moved to their active level
		function void catch_edges(bit [DATA_W-1:0] changed);
			st_r |= changed & ie_r & ~trig_r & ~(lv_r ^ pol_r) & pins;
		endfunction

		// Drive output pins from the latch, then re-evaluate level status
		function void settle_pins();
			bit [DATA_W-1:0] outs;
			bit [DATA_W-1:0] prev;
			bit [DATA_W-1:0] seen;
			bit [DATA_W-1:0] lvl;
			outs = dir_r & pins;
			prev = lv_r;
			lv_r = (lv_r & ~outs) | (latch_r & outs);
			catch_edges((prev ^ lv_r) & pins);
			seen = (dir_r & latch_r) | (~dir_r & lv_r);
			lvl = ie_r & trig_r & pins;
			st_r = (st_r & ~lvl) | (lvl & ~(seen ^ pol_r));
		endfunction

		function bit [DATA_W-1:0] reg_value(logic [2:0] idx);
			case (idx)
				REG_DIR:  return dir_r;
				REG_OUT:  return latch_r;
				REG_IN:   return ((dir_r & latch_r) | (~dir_r & lv_r)) & pins;
				REG_IE:   return ie_r;
				REG_IS:   return st_r;
				REG_TRIG: return trig_r;
				REG_POL:  return pol_r;
				default:  return '0;
			endcase
		endfunction

		// Apply one accepted item and queue the result it should produce
		function void note_item(in_item_t it);
			out_item_t exp;
			bit [DATA_W-1:0] prev;
			exp.read_data = '0;
			case (it.kind)
				KIND_READ: begin
					exp.read_data = reg_value(it.reg_index);
				end
				KIND_WRITE: begin
					case (it.reg_index)
						REG_DIR: begin
							dir_r = it.write_value;
							settle_pins();
						end
						REG_OUT: begin
							latch_r = it.write_value;
							settle_pins();
						end
						REG_IE:   ie_r = it.write_value;
						REG_IS:   st_r &= ~it.write_value;
						REG_TRIG: begin
							trig_r = it.write_value;
							settle_pins();
						end
						REG_POL: begin
							pol_r = it.write_value;
							settle_pins();
						end
						default: ;
					endcase
				end
				KIND_PIN: begin
					if (int'(it.pin_index) < pin_count) begin
						prev = lv_r;
						lv_r[it.pin_index] = it.write_value[0];
						catch_edges((prev ^ lv_r) & pins);
						settle_pins();
					end
				end
				default: ;
			endcase
			exp.irq = ((st_r & ie_r) != '0);
			exp.drive_lines = latch_r & dir_r & pins;
			pending_results.push_back(exp);
		endfunction

		// Compare one accepted result with the oldest queued expectation
		function void check_result(out_item_t got);
			out_item_t exp;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: read_data %h irq %b drive_lines %h",
						got.read_data, got.irq, got.drive_lines);
				return;
			end
			exp = pending_results.pop_front();
			if (got.read_data !== exp.read_data || got.irq !== exp.irq ||
					got.drive_lines !== exp.drive_lines) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: expected rd %h irq %b drv %h, got rd %h irq %b drv %h",
						exp.read_data, exp.irq, exp.drive_lines,
						got.read_data, got.irq, got.drive_lines);
			end
		endfunction

		function int pending();
			return pending_results.size();
		endfunction
	endclass

endpackage

>>> tb/testbench.sv
// Top-level testbench of the GPIO controller with edge and level interrupts
`timescale 1ns / 1ps

module testbench;

	import gpio_eli_pkg::*;
	import gpio_eli_shadow_pkg::*;

	localparam int PIN_CNT      = 32;
	localparam int RANDOM_ITEMS = 1750;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      item_valid = 1'b0;
	logic      item_stall;
	in_item_t  item = '0;
	logic      result_valid;
	logic      result_stall = 1'b0;
	out_item_t result;

	gpio_shadow_regs shadow = new(PIN_CNT);

	gpio_controller_edge_level_irq #(
		.NUM_PINS(PIN_CNT)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	// Clock
	initial begin
		forever #5 clk = ~clk;
	end

	// Reset once at the start
	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Hard limit on the run
	initial begin
		#3000000;
		$display("status: fail");
		$finish;
	end

	function automatic in_item_t make_item(logic [1:0] kind, logic [2:0] idx,
			logic [DATA_W-1:0] value, logic [PIN_W-1:0] pin);
		in_item_t it;
		it.kind = kind;
		it.reg_index = idx;
		it.write_value = value;
		it.pin_index = pin;
		return it;
	endfunction

	// Draw one item: mostly pin activity, config writes and reads
	function automatic in_item_t random_item();
		in_item_t it;
		int pick;
		it.kind = KIND_READ;
		it.reg_index = 3'($urandom_range(0, 7));
		it.write_value = $urandom;
		it.pin_index = 5'($urandom_range(0, 31));
		pick = $urandom_range(0, 99);
		if (pick < 30) begin
			it.kind = KIND_PIN;
		end else if (pick < 55) begin
			it.kind = KIND_WRITE;
			case ($urandom_range(0, 3))
				0:       it.reg_index = REG_DIR;
				1:       it.reg_index = REG_OUT;
				2:       it.reg_index = REG_TRIG;
				default: it.reg_index = REG_POL;
			endcase
		end else if (pick < 65) begin
			it.kind = KIND_WRITE;
			it.reg_index = REG_IE;
		end else if (pick < 75) begin
			it.kind = KIND_WRITE;
			it.reg_index = REG_IS;
		end else if (pick < 95) begin
			it.kind = KIND_READ;
		end else if (pick < 98) begin
			it.kind = KIND_SPARE;
		end else begin
			it.kind = KIND_WRITE;
			it.reg_index = ($urandom_range(0, 1) == 0) ? REG_IN : REG_NONE;
		end
		// Push some words to the extremes
		case ($urandom_range(0, 9))
			0:       it.write_value = '0;
			1:       it.write_value = '1;
			default: ;
		endcase
		return it;
	endfunction

	// Idle gap for one item; every third block of 64 items runs without gaps
	function automatic int draw_gap(int count);
		if ((count / 64) % 3 == 0)
			return 0;
		return $urandom_range(0, 14);
	endfunction

	// Present one item and hold it until accepted
	task automatic send_item(in_item_t it, int gap);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		shadow.note_item(it);
	endtask

	// Hold off the sender until every queued result has come back
	task automatic drain_results();
		item_valid <= 1'b0;
		@(posedge clk);
		while (shadow.pending() != 0) @(posedge clk);
	endtask

	// Result side: stall at random, check each accepted result
	initial begin
		int gap;
		int taken;
		taken = 0;
		@(posedge arst_n);
		forever begin
			gap = draw_gap(taken + 32);
			if (gap > 0) begin
				result_stall <= 1'b1;
				repeat (gap) @(posedge clk);
			end
			result_stall <= 1'b0;
			@(posedge clk);
			while (!result_valid) @(posedge clk);
			shadow.check_result(result);
			taken++;
		end
	end

	// Item side: directed items, then random ones
	initial begin
		in_item_t directed[$];
		int sent;
		sent = 0;
		directed.push_back(make_item(KIND_READ, REG_IN, '1, 5'd0));
		directed.push_back(make_item(KIND_READ, REG_NONE, '1, 5'd31));
		directed.push_back(make_item(KIND_WRITE, REG_IE, '1, 5'd0));
		directed.push_back(make_item(KIND_WRITE, REG_POL, '1, 5'd0));
		directed.push_back(make_item(KIND_WRITE, REG_TRIG, '0, 5'd0));
		// Rising edges on active-high edge pins, then a fall on pin 31
		directed.push_back(make_item(KIND_PIN, REG_DIR, 32'd1, 5'd0));
		directed.push_back(make_item(KIND_PIN, REG_DIR, 32'hFFFF_FFFF, 5'd31));
		directed.push_back(make_item(KIND_PIN, REG_DIR, 32'hFFFF_FFFE, 5'd31));
		directed.push_back(make_item(KIND_READ, REG_IS, '0, 5'd0));
		directed.push_back(make_item(KIND_WRITE, REG_IS, '1, 5'd0));
		directed.push_back(make_item(KIND_WRITE, REG_DIR, 32'hFFFF_0000, 5'd0));
		directed.push_back(make_item(KIND_WRITE, REG_OUT, 32'hAAAA_AAAA, 5'd0));
		// Pin event on an output pin reverts to the latch
		directed.push_back(make_item(KIND_PIN, REG_DIR, 32'd0, 5'd17));
		directed.push_back(make_item(KIND_WRITE, REG_TRIG, '1, 5'd0));
		directed.push_back(make_item(KIND_WRITE, REG_POL, '0, 5'd0));
		directed.push_back(make_item(KIND_READ, REG_IS, '0, 5'd0));
		directed.push_back(make_item(KIND_READ, REG_IN, '0, 5'd0));
		// Writes to the input register and the unmapped slot are dropped
		directed.push_back(make_item(KIND_WRITE, REG_IN, '1, 5'd0));
		directed.push_back(make_item(KIND_WRITE, REG_NONE, '1, 5'd0));
		directed.push_back(make_item(KIND_SPARE, REG_DIR, '1, 5'd31));
		directed.push_back(make_item(KIND_READ, REG_DIR, '0, 5'd0));
		directed.push_back(make_item(KIND_READ, REG_OUT, '0, 5'd0));
		directed.push_back(make_item(KIND_READ, REG_TRIG, '0, 5'd0));
		directed.push_back(make_item(KIND_READ, REG_POL, '0, 5'd0));
		directed.push_back(make_item(KIND_WRITE, REG_IE, '0, 5'd0));

		@(posedge arst_n);
		@(posedge clk);
		foreach (directed[i]) begin
			send_item(directed[i], draw_gap(sent + 64));
			sent++;
		end
		drain_results();
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == 600 || n == 1200)
				drain_results();
			send_item(random_item(), draw_gap(n));
		end
		item_valid <= 1'b0;

		// Let the pipeline empty, then report
		while (shadow.pending() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (shadow.mismatches == 0 && shadow.pending() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
